// File: hw/rtl/fmcrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcrw_pkg: shared types and constants of the FM channel register writer
// Field widths, register bases, frequency conversion constants, the
// operator offset table and the level scaling function.
// ----------------------------------------------------------------------------
package fmcrw_pkg;

  // field widths
  localparam int CH_W    = 4;
  localparam int HZ_W    = 31;
  localparam int VOL_W   = 6;
  localparam int LVL_W   = 8;
  localparam int ADDR_W  = 8;
  localparam int DATA_W  = 8;
  localparam int OPOFF_W = 5;
  localparam int BLOCK_W = 5;
  localparam int FNUM_W  = 10;
  localparam int FREQ_W  = 32;

  // channel count of the synth
  localparam int NUM_CHANNELS = 9;

  // shadow register file
  localparam int                SHADOW_DEPTH = 256;
  localparam logic [DATA_W-1:0] SHADOW_INIT  = 8'hFC;

  // normalization thresholds: limit for a shift by 1, 2, 4 and 8
  localparam logic [FREQ_W-1:0] FREQ_LIM_1 = 32'd3125;
  localparam logic [FREQ_W-1:0] FREQ_LIM_2 = 32'd6250;
  localparam logic [FREQ_W-1:0] FREQ_LIM_4 = 32'd25000;
  localparam logic [FREQ_W-1:0] FREQ_LIM_8 = 32'd400000;

  // fnum = (f << 10) / 3125 as a reciprocal multiply, exact for f < 3125
  localparam int          RECIP_W    = 23;
  localparam int          DIVIN_W    = 22;
  localparam int          PROD_W     = DIVIN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] FNUM_RECIP = 23'd5497559;
  localparam int          FNUM_SHIFT = 34;

  // register bases and bit masks
  localparam logic [ADDR_W-1:0] MOD_BASE    = 8'h40;
  localparam logic [ADDR_W-1:0] CAR_BASE    = 8'h43;
  localparam logic [ADDR_W-1:0] FLO_BASE    = 8'hA0;
  localparam logic [ADDR_W-1:0] FHI_BASE    = 8'hB0;
  localparam logic [DATA_W-1:0] KEYOFF_HI   = 8'hDF;
  localparam logic [DATA_W-1:0] BLOCK_MARK  = 8'h20;

  // retrigger mode codes
  localparam logic [1:0] RETRIG_ON_ONLY  = 2'd0;
  localparam logic [1:0] RETRIG_OFF_ON   = 2'd1;
  localparam logic [1:0] RETRIG_OFF_ONLY = 2'd2;

  // candidate write slots, in issue order
  localparam int NUM_CAND = 6;
  localparam int C_OFF_LO = 0;
  localparam int C_OFF_HI = 1;
  localparam int C_ON_LO  = 2;
  localparam int C_ON_HI  = 3;
  localparam int C_MOD    = 4;
  localparam int C_CAR    = 5;

  // classified channel update
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [OPOFF_W-1:0] op_off;
    logic               do_freq;
    logic               key_off;
    logic               key_on;
    logic               do_mod;
    logic               do_car;
    logic [HZ_W-1:0]    hz;
    logic [DATA_W-1:0]  mod_data;
    logic [DATA_W-1:0]  car_data;
  } cmd_t;

  // one candidate register write
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } cand_t;

  // status of the shadow stage
  typedef struct packed {
    logic clearing;
  } shd_stat_t;

  // operator register offset of a channel
  function automatic logic [OPOFF_W-1:0] op_offset(input logic [CH_W-1:0] ch);
    logic [OPOFF_W-1:0] off;
    case (ch)
      4'd0:    off = 5'd0;
      4'd1:    off = 5'd1;
      4'd2:    off = 5'd2;
      4'd3:    off = 5'd8;
      4'd4:    off = 5'd9;
      4'd5:    off = 5'd10;
      4'd6:    off = 5'd16;
      4'd7:    off = 5'd17;
      4'd8:    off = 5'd18;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // attenuate a total level byte by the channel volume, keep key-scale bits
  function automatic logic [DATA_W-1:0] scale_level(input logic [LVL_W-1:0] lvl,
                                                    input logic [VOL_W-1:0] vol);
    logic [5:0]  t;
    logic [6:0]  v;
    logic [12:0] prod;
    logic [5:0]  ts;
    t    = ~lvl[5:0];
    v    = (vol != 6'd0) ? ({1'b0, vol} + 7'd1) : 7'd0;
    prod = 13'(t) * 13'(v);
    ts   = (vol != 6'd63) ? prod[11:6] : t;
    return {lvl[7:6], ~ts};
  endfunction

endpackage

// File: hw/rtl/fm_channel_register_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_channel_register_writer: FM channel update to synth register writes
// Results: a write is shown once the next write of the update or its end
//   is known; the first result of an update comes later when a frequency
//   is sent or leading writes are suppressed.
// Sequencing: the back-end sequencer holds one update at a time, through
//   the load, the halving steps and the multiply when a frequency is sent,
//   then one candidate write (up to 6) per step, held while results stall.
// Reset: synchronous; afterwards full stays high while the shadow register
//   file is swept to 0xFC.
// ----------------------------------------------------------------------------
module fm_channel_register_writer #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [fmcrw_pkg::CH_W-1:0]    channel,
  input  logic                          freq_pending,
  input  logic [fmcrw_pkg::HZ_W-1:0]    hz,
  input  logic [1:0]                    retrig_mode,
  input  logic                          vol_update,
  input  logic                          has_instrument,
  input  logic [fmcrw_pkg::VOL_W-1:0]   volume,
  input  logic [fmcrw_pkg::LVL_W-1:0]   mod_level,
  input  logic [fmcrw_pkg::LVL_W-1:0]   car_level,
  input  logic                          additive,
  output logic                          empty,
  input  logic                          pop,
  output logic [fmcrw_pkg::ADDR_W-1:0]  reg_addr,
  output logic [fmcrw_pkg::DATA_W-1:0]  reg_data,
  output logic                          last_write
);
  import fmcrw_pkg::*;

  shd_stat_t stat;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      cand_valid;
  cand_t     cand;
  logic      cand_ready;

  // intake and classification
  fmcrw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .channel        (channel),
    .freq_pending   (freq_pending),
    .hz             (hz),
    .retrig_mode    (retrig_mode),
    .vol_update     (vol_update),
    .has_instrument (has_instrument),
    .volume         (volume),
    .mod_level      (mod_level),
    .car_level      (car_level),
    .additive       (additive),
    .stat           (stat),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // frequency conversion and write sequencing
  fmcrw_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .cand_valid (cand_valid),
    .cand       (cand),
    .cand_ready (cand_ready)
  );

  // shadow filter and result queue
  fmcrw_shadow #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_shadow (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand       (cand),
    .cand_ready (cand_ready),
    .stat       (stat),
    .pop        (pop),
    .empty      (empty),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .last_write (last_write)
  );

  // no candidate may reach the shadow while it is being swept
  a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !(cand_valid && cand_ready))
    else $error("candidate transfer during shadow clearing");

  // a stalled candidate is held by the sequencer
  a_cand_hold: assert property (@(posedge clk) disable iff (rst)
    cand_valid && !cand_ready |=> cand_valid && $stable(cand))
    else $error("candidate changed while stalled");

  // the sequencer takes commands only from a non-empty queue
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

// File: hw/rtl/fmcrw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcrw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered (old data on a
// read of the address being written).
// ----------------------------------------------------------------------------
module fmcrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/fmcrw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcrw_front: item intake and classification
// Checks the channel, decides which writes an update needs, scales the
// operator levels and queues the result for the back end.
// ----------------------------------------------------------------------------
module fmcrw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [fmcrw_pkg::CH_W-1:0]    channel,
  input  logic                          freq_pending,
  input  logic [fmcrw_pkg::HZ_W-1:0]    hz,
  input  logic [1:0]                    retrig_mode,
  input  logic                          vol_update,
  input  logic                          has_instrument,
  input  logic [fmcrw_pkg::VOL_W-1:0]   volume,
  input  logic [fmcrw_pkg::LVL_W-1:0]   mod_level,
  input  logic [fmcrw_pkg::LVL_W-1:0]   car_level,
  input  logic                          additive,
  input  fmcrw_pkg::shd_stat_t          stat,
  output logic                          cmd_valid,
  output fmcrw_pkg::cmd_t               cmd,
  input  logic                          cmd_pop
);
  import fmcrw_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  cmd_t           queue [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  cmd_t new_cmd;
  logic ch_ok;
  logic lvl_ok;
  logic accept;
  logic store;

  // classify the incoming update
  always_comb begin
    ch_ok            = channel < CH_W'(NUM_CHANNELS);
    lvl_ok           = ch_ok & vol_update & has_instrument;
    new_cmd.channel  = channel;
    new_cmd.op_off   = op_offset(channel);
    new_cmd.do_freq  = ch_ok & freq_pending;
    new_cmd.key_off  = retrig_mode != RETRIG_ON_ONLY;
    new_cmd.key_on   = retrig_mode != RETRIG_OFF_ONLY;
    new_cmd.do_mod   = lvl_ok & additive;
    new_cmd.do_car   = lvl_ok;
    new_cmd.hz       = hz;
    new_cmd.mod_data = scale_level(mod_level, volume);
    new_cmd.car_data = scale_level(car_level, volume);
  end

  // updates with nothing to write are dropped here
  assign full   = stat.clearing | (count == QCW'(QDEPTH));
  assign accept = push & ~full;
  assign store  = accept & (new_cmd.do_freq | new_cmd.do_car);

  // command queue toward the back end
  always_ff @(posedge clk) begin
    if (store) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (store) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({store, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign cmd_valid = count != '0;
  assign cmd       = queue[rd_ptr];

endmodule

// File: hw/rtl/fmcrw_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcrw_exec: back end sequencer
// Normalizes the frequency into block and fnum, then issues the candidate
// register writes of one update in order, one per cycle unless the filter stalls.
// ----------------------------------------------------------------------------
module fmcrw_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  fmcrw_pkg::cmd_t    cmd,
  output logic               cmd_pop,
  output logic               cand_valid,
  output fmcrw_pkg::cand_t   cand,
  input  logic               cand_ready
);
  import fmcrw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_NORM  = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_ISSUE = 4'b1000
  } state_t;

  state_t              state;
  cmd_t                cur;
  logic [NUM_CAND-1:0] mask;
  logic [FREQ_W-1:0]   f;
  logic [BLOCK_W-1:0]  blk;
  logic [PROD_W-1:0]   prod;
  logic [DATA_W-1:0]   note_lo;
  logic [DATA_W-1:0]   note_hi;

  logic [NUM_CAND-1:0] pick;
  logic [NUM_CAND-1:0] rest;
  logic [ADDR_W-1:0]   slot_addr [NUM_CAND];
  logic [DATA_W-1:0]   slot_data [NUM_CAND];
  logic [FNUM_W-1:0]   fnum;
  logic                issue;

  assign cmd_pop = (state == ST_IDLE) & cmd_valid;
  assign fnum    = prod[FNUM_SHIFT +: FNUM_W];

  // candidate table of the current update
  always_comb begin
    slot_addr[C_OFF_LO] = FLO_BASE + ADDR_W'(cur.channel);
    slot_addr[C_OFF_HI] = FHI_BASE + ADDR_W'(cur.channel);
    slot_addr[C_ON_LO]  = FLO_BASE + ADDR_W'(cur.channel);
    slot_addr[C_ON_HI]  = FHI_BASE + ADDR_W'(cur.channel);
    slot_addr[C_MOD]    = MOD_BASE + ADDR_W'(cur.op_off);
    slot_addr[C_CAR]    = CAR_BASE + ADDR_W'(cur.op_off);
    slot_data[C_OFF_LO] = note_lo;
    slot_data[C_OFF_HI] = note_hi & KEYOFF_HI;
    slot_data[C_ON_LO]  = note_lo;
    slot_data[C_ON_HI]  = note_hi;
    slot_data[C_MOD]    = cur.mod_data;
    slot_data[C_CAR]    = cur.car_data;
  end

  // lowest pending slot goes next
  always_comb begin
    pick      = mask & (~mask + 1'b1);
    rest      = mask & ~pick;
    cand.addr = '0;
    cand.data = '0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (pick[i]) begin
        cand.addr = slot_addr[i];
        cand.data = slot_data[i];
      end
    end
    cand.last = rest == '0;
  end

  assign cand_valid = state == ST_ISSUE;
  assign issue      = cand_valid & cand_ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= cmd.do_freq ? ST_NORM : ST_ISSUE;
          end
        end
        ST_NORM: begin
          if (f < FREQ_LIM_1) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (issue && cand.last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: load, normalize by up to eight halvings a cycle, divide
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur  <= cmd;
          mask <= {cmd.do_car, cmd.do_mod,
                   {2{cmd.do_freq & cmd.key_on}},
                   {2{cmd.do_freq & cmd.key_off}}};
          f    <= {cmd.hz, 1'b0};
          blk  <= '0;
        end
      end
      ST_NORM: begin
        if (f >= FREQ_LIM_8) begin
          f   <= f >> 8;
          blk <= blk + 5'd8;
        end else if (f >= FREQ_LIM_4) begin
          f   <= f >> 4;
          blk <= blk + 5'd4;
        end else if (f >= FREQ_LIM_2) begin
          f   <= f >> 2;
          blk <= blk + 5'd2;
        end else if (f >= FREQ_LIM_1) begin
          f   <= f >> 1;
          blk <= blk + 5'd1;
        end else begin
          prod <= PROD_W'({f[11:0], 10'b0}) * PROD_W'(FNUM_RECIP);
        end
      end
      ST_MUL: begin
        note_lo <= fnum[7:0];
        note_hi <= {1'b0, blk, 2'b00} | BLOCK_MARK | {6'b0, fnum[9:8]};
      end
      ST_ISSUE: begin
        if (issue) begin
          mask <= rest;
        end
      end
      default: begin
        mask <= mask;
      end
    endcase
  end

endmodule

// File: hw/rtl/fmcrw_shadow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcrw_shadow: write filter and result queue
// Compares each candidate with the shadow register file, drops repeats,
// marks the final write of an update and queues the results.
// ----------------------------------------------------------------------------
module fmcrw_shadow #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cand_valid,
  input  fmcrw_pkg::cand_t               cand,
  output logic                           cand_ready,
  output fmcrw_pkg::shd_stat_t           stat,
  input  logic                           pop,
  output logic                           empty,
  output logic [fmcrw_pkg::ADDR_W-1:0]   reg_addr,
  output logic [fmcrw_pkg::DATA_W-1:0]   reg_data,
  output logic                           last_write
);
  import fmcrw_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int SW = $clog2(SHADOW_DEPTH);

  // clearing pass
  logic          clearing;
  logic [SW-1:0] clr_idx;

  // compare stage and forwarding of the previous write
  logic              c_valid;
  cand_t             c;
  logic              fw_valid;
  logic [ADDR_W-1:0] fw_addr;
  logic [DATA_W-1:0] fw_data;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] old_data;
  logic              wr_new;

  // result held until the next result or the end of the update
  logic  pend_valid;
  cand_t pend;
  logic  push_pend;
  cand_t push_item;

  // result queue
  cand_t         fifo [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;
  logic [CW+1:0] outstanding;

  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  assign stat.clearing = clearing;

  // shadow memory, swept to its reset value after reset
  assign ram_we    = clearing | wr_new;
  assign ram_waddr = clearing ? clr_idx : SW'(c.addr);
  assign ram_wdata = clearing ? SHADOW_INIT : c.data;

  fmcrw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SHADOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (SW'(cand.addr)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == SW'(SHADOW_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // issue only when every result in flight still has a queue slot
  assign outstanding = (CW+2)'(count) + (CW+2)'(c_valid) + (CW+2)'(pend_valid)
                     + (CW+2)'(1);
  assign cand_ready  = ~clearing & (outstanding <= (CW+2)'(OUT_DEPTH));

  // compare with the shadow, the write of the previous cycle wins
  assign old_data = (fw_valid && fw_addr == c.addr) ? fw_data : rdata;
  assign wr_new   = c_valid & (old_data != c.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid  <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      c_valid  <= cand_valid & cand_ready;
      fw_valid <= wr_new;
    end
  end

  always_ff @(posedge clk) begin
    c       <= cand;
    fw_addr <= c.addr;
    fw_data <= c.data;
  end

  // final-write marking
  assign push_pend = pend_valid & (pend.last | wr_new | (c_valid & c.last));

  always_comb begin
    push_item      = pend;
    push_item.last = pend.last | (c_valid & c.last & ~wr_new);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (wr_new) begin
      pend_valid <= 1'b1;
    end else if (push_pend) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      pend <= c;
    end
  end

  // result queue transfer
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (push_pend) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_pend) begin
        wr_ptr <= (wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_pend, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign empty      = count == '0;
  assign reg_addr   = fifo[rd_ptr].addr;
  assign reg_data   = fifo[rd_ptr].data;
  assign last_write = fifo[rd_ptr].last;

endmodule
